>>> rtl/sidta_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
// Holds the sequencer state type, ASCII codes and BCD correction constants.
// No dependencies.
package sidta_pkg;

    // Width of one emitted character and of one BCD digit
    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;

    // Output tdata is the character padded to a whole byte
    localparam int M_TDATA_W = 8;

    // ASCII codes (all fit in six bits)
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    // Shift-and-add-3 correction
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII: top level with sequencer and datapath registers.
// Uses sidta_dabble as the shared conversion step and sidta_pkg for types.
//
// One request on the s_ side carries a VALUE_BITS-bit two's complement integer;
// the m_ side then delivers its decimal text one ASCII character per request,
// most significant digit first, '-' in front of negative values, no leading
// zeros, tlast on the final character. The magnitude is converted by a single
// shift-and-add-3 unit, one input bit per cycle; then the sign is sent for
// negative values, and each BCD digit position (NUM_DIGITS, 10 for 32 bits)
// is either skipped as a leading zero or emitted. s_tready is high only
// between numbers.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32,
    localparam int S_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: value[VALUE_BITS-1:0], zero padded to bytes
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_TDATA_W-1:0]            s_tdata,
    // m_tdata: text_char[5:0], zeros above
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sidta_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import sidta_pkg::*;

    // Enough digits for 2^(VALUE_BITS-1); log10(2) ~ 0.302
    localparam int NUM_DIGITS = (VALUE_BITS * 302) / 1000 + 1;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam logic [VALUE_BITS-1:0] MAG_ONE = VALUE_BITS'(1);

    state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      dig_reg, dig_next;
    logic                  started_reg, started_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     m_char_reg, m_char_next;
    logic                  m_last_reg, m_last_next;

    logic [VALUE_BITS-1:0] in_value;
    logic [BCD_W-1:0]      bcd_step;
    logic [DIGIT_W-1:0]    cur_digit;
    logic                  out_free;
    logic                  dig_is_last;
    logic                  skip_zero;

    // Shared conversion step
    sidta_dabble #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_dabble (
        .bcd_in (bcd_reg),
        .bit_in (bin_reg[VALUE_BITS-1]),
        .bcd_out(bcd_step)
    );

    assign in_value    = s_tdata[VALUE_BITS-1:0];
    assign cur_digit   = bcd_reg[{dig_reg, 2'b00} +: DIGIT_W];
    assign out_free    = !m_valid_reg || m_tready;
    assign dig_is_last = (dig_reg == '0);
    assign skip_zero   = !started_reg && (cur_digit == '0) && !dig_is_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_char_reg);
    assign m_tlast  = m_last_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CONV;
            end
            ST_CONV: begin
                if (cnt_reg == '0) state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
                if (out_free) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!skip_zero && out_free && dig_is_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        dig_next     = dig_reg;
        started_next = started_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    neg_next = in_value[VALUE_BITS-1];
                    bin_next = in_value[VALUE_BITS-1] ? (~in_value) + MAG_ONE : in_value;
                    bcd_next = '0;
                    cnt_next = CNT_W'(VALUE_BITS - 1);
                end
            end
            ST_CONV: begin
                bcd_next     = bcd_step;
                bin_next     = {bin_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next     = cnt_reg - CNT_W'(1);
                dig_next     = IDX_W'(NUM_DIGITS - 1);
                started_next = 1'b0;
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_MINUS;
                    m_last_next  = 1'b0;
                end
            end
            ST_EMIT: begin
                if (skip_zero) begin
                    dig_next = dig_reg - IDX_W'(1);
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_ZERO + CHAR_W'(cur_digit);
                    m_last_next  = dig_is_last;
                    started_next = 1'b1;
                    if (!dig_is_last) dig_next = dig_reg - IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        cnt_reg     <= cnt_next;
        dig_reg     <= dig_next;
        started_reg <= started_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

`ifndef SYNTHESIS
    // No character is loaded while the conversion is running
    a_no_load_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |=> !$rose(m_valid_reg))
        else $error("output loaded during conversion");

    // Conversion runs until the step counter is exhausted
    a_conv_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && cnt_reg != '0) |=> (state_reg == ST_CONV))
        else $error("conversion ended early");

    // Every character is a minus sign or a decimal digit
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_char_reg == CHAR_MINUS ||
                         (m_char_reg >= CHAR_ZERO &&
                          m_char_reg <= CHAR_ZERO + CHAR_W'(DIGIT_MAX))))
        else $error("character out of range");

    // A minus sign never ends a run
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_char_reg == CHAR_MINUS) |-> !m_last_reg)
        else $error("minus sign marked last");
`endif

endmodule

>>> rtl/sidta_dabble.sv
// One shift-and-add-3 step of the binary to BCD converter.
// Corrects every digit of 5 or more, then shifts in one binary bit.
// Depends on sidta_pkg.
module sidta_dabble #(
    parameter int NUM_DIGITS = 10
) (
    input  logic [NUM_DIGITS*sidta_pkg::DIGIT_W-1:0] bcd_in,
    input  logic                                     bit_in,
    output logic [NUM_DIGITS*sidta_pkg::DIGIT_W-1:0] bcd_out
);
    import sidta_pkg::*;

    logic [NUM_DIGITS*DIGIT_W-1:0] adj;

    // Per-digit correction, digits are independent
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_in[i*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Shift the whole BCD word left by one, new bit at the bottom
    assign bcd_out = {adj[NUM_DIGITS*DIGIT_W-2:0], bit_in};

endmodule

>>> tb/sidta_text_checker.sv
// Checker for the signed integer to decimal ASCII converter: watches both stream channels.
// Predicts each number's text and compares every character request in order.
// Depends on sidta_pkg for character width and ASCII codes.
`timescale 1ns / 100ps

module sidta_text_checker #(
    parameter int VALUE_BITS = 32,
    localparam int S_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: value[VALUE_BITS-1:0], zero padded to bytes
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [S_TDATA_W-1:0]            s_tdata,
    // m_tdata: text_char[5:0], zeros above
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sidta_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast,
    output int                              mismatches,
    output int                              pending,
    output int                              chars_checked,
    output int                              numbers_seen
);
    import sidta_pkg::*;

    localparam int DECIMAL_BASE = 10;
    localparam int MAX_DIGITS   = 24;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last;
    } ascii_char_t;

    // characters still owed by the block, oldest first
    ascii_char_t text_q[$];

    initial begin
        mismatches    = 0;
        pending       = 0;
        chars_checked = 0;
        numbers_seen  = 0;
    end

    // Decimal text of one two's complement value, sign first, no leading zeros
    function automatic void queue_decimal_text(logic [VALUE_BITS-1:0] value);
        logic                  negative;
        logic [VALUE_BITS:0]   magnitude;
        logic [DIGIT_W-1:0]    digits [MAX_DIGITS];
        int                    ndig;
        ascii_char_t           c;
        negative  = value[VALUE_BITS-1];
        // one bit wider so the most negative value has an exact magnitude
        magnitude = negative ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
        ndig = 0;
        do begin
            digits[ndig] = DIGIT_W'(magnitude % DECIMAL_BASE);
            magnitude    = magnitude / DECIMAL_BASE;
            ndig++;
        end while (magnitude != 0 && ndig < MAX_DIGITS);
        if (negative) begin
            c.text_char = CHAR_MINUS;
            c.last      = 1'b0;
            text_q.push_back(c);
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            c.text_char = CHAR_W'(CHAR_ZERO + digits[k]);
            c.last      = (k == 0);
            text_q.push_back(c);
        end
    endfunction

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        ascii_char_t                   exp_c;
        logic [M_TDATA_W-1:0]          exp_data;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                queue_decimal_text(s_tdata[VALUE_BITS-1:0]);
                numbers_seen++;
            end
            if (m_tvalid && m_tready) begin
                chars_checked++;
                if (text_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected character: expected none, got tdata %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    exp_c    = text_q.pop_front();
                    exp_data = {{(M_TDATA_W - CHAR_W){1'b0}}, exp_c.text_char};
                    if (m_tdata !== exp_data || m_tlast !== exp_c.last) begin
                        mismatches++;
                        $display("%0t: mismatch: expected tdata %h last %b, got tdata %h last %b",
                                 $time, exp_data, exp_c.last, m_tdata, m_tlast);
                    end
                end
            end
        end
        pending = text_q.size();
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for signed_int_to_decimal_ascii: clock, reset, stimulus and verdict.
// Drives numbers on the s_ side, stalls the m_ side, and relies on sidta_text_checker.
// Depends on sidta_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_top;
    import sidta_pkg::*;

    localparam int  VALUE_BITS     = 32;
    localparam int  S_TDATA_W      = ((VALUE_BITS + 7) / 8) * 8;
    localparam int  HALF_PERIOD_NS = 2;
    localparam int  RESET_CYCLES   = 5;
    localparam int  SETTLE_CYCLES  = 60;      // a bit more than one conversion
    localparam int  RX_HOLD_CYCLES = 400;
    localparam int  PHASE_ITEMS    = 137;
    localparam time TIMEOUT_NS     = 4_000_000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int mismatches;
    int pending;
    int chars_checked;
    int numbers_seen;

    // idling percentages and the long output stall request
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_req_cnt = 0;
    int hold_ack_cnt = 0;
    int hold_left    = 0;

    always #(HALF_PERIOD_NS) aclk = ~aclk;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    sidta_text_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .pending      (pending),
        .chars_checked(chars_checked),
        .numbers_seen (numbers_seen)
    );

    // Output side ready: random stalls, or a long hold when requested
    always @(negedge aclk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one number, idling first at random; returns right after the accept edge
    task automatic send_number(input logic [VALUE_BITS-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(value);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait for the text of everything accepted so far
    task automatic drain_text();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Half of the values are decade-shaped so every run length shows up often
    function automatic logic [VALUE_BITS-1:0] random_number();
        logic [VALUE_BITS-1:0] v;
        int unsigned           lo;
        int unsigned           hi;
        int                    k;
        case ($urandom_range(3))
            0: v = $urandom;
            1, 2: begin
                k  = $urandom_range(9);
                lo = (k == 0) ? 0 : 1;
                repeat (k) begin
                    if (lo != 1 || k > 0) lo = lo * 10;
                end
                lo = (k == 0) ? 0 : lo / 10 * 10;
                hi = (k == 9) ? 32'h7FFF_FFFF : ((k == 0) ? 9 : lo * 10 - 1);
                v  = $urandom_range(hi, lo);
                if ($urandom_range(1)) v = -v;
            end
            default: begin
                // near the extremes and around zero
                case ($urandom_range(2))
                    0: v = 32'h7FFF_FFFF - $urandom_range(3);
                    1: v = 32'h8000_0000 + $urandom_range(3);
                    default: v = $urandom_range(3) - 2;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [VALUE_BITS-1:0] directed [$];
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                     32'd2147483647, 32'h8000_0000, -32'sd2147483647, 32'd1000000000,
                     32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
                     32'd5, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFF6, 32'd4294967286,
                     32'd1000000001};

        // synchronous reset, once
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed values with no idling
        foreach (directed[i]) send_number(directed[i]);
        drain_text();

        // sender mostly busy, receiver mostly stalled
        tx_idle_pct = 25;
        rx_idle_pct = 83;
        repeat (PHASE_ITEMS) send_number(random_number());
        drain_text();

        // sender mostly idle, receiver mostly ready
        tx_idle_pct = 83;
        rx_idle_pct = 25;
        repeat (PHASE_ITEMS) send_number(random_number());
        drain_text();

        // no idling; one long output stall while numbers keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (PHASE_ITEMS / 2) send_number(random_number());
        hold_req_cnt++;
        repeat (12) send_number(random_number());
        drain_text();
        repeat (PHASE_ITEMS / 2) send_number(random_number());
        drain_text();

        $display("Run covered %0d numbers and %0d characters: directed extremes, decade sweeps,",
                 numbers_seen, chars_checked);
        $display("both idling mixes, back-to-back traffic and a %0d-cycle output stall.",
                 RX_HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb_top failed");
        $finish;
    end

endmodule
